[rtl/three_anchor_trilateration_polar_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the trilateration block
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef THREE_ANCHOR_TRILATERATION_POLAR_TOP_MACROS_SVH
`define THREE_ANCHOR_TRILATERATION_POLAR_TOP_MACROS_SVH

`ifndef SYNTH
`define TAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define TAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TAT_ASSERT(lbl, prop)
`define TAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/tat_pkg.sv]
// ----------------------------------------------------------------------------
// tat_pkg
// Widths, register codes, stage structs and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS
                                                                    : ATAN_LEN;
  localparam int SQ_W              = 16;
  localparam int SQ_REM_W          = 2 * SQ_W;
  localparam int SQRT_STEPS        = SQ_W;
  localparam int POLAR_STEPS       = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  localparam int COEF_W = 18;
  localparam int CF_W   = 35;
  localparam int DET_W  = 36;
  localparam int NUM_W  = 54;
  localparam int DEN_W  = 35;
  localparam int MAG_W  = 54;
  localparam int QUO_W  = 18;
  localparam int CRD_W  = 36;
  localparam int ANG_W  = 26;
  localparam int ANG_SHIFT = 8;

  localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd4608000;
  localparam logic signed [ANG_W-1:0] ANG_HALF  = 26'sd128;
  localparam logic signed [ANG_W-1:0] CD_MAX    = 26'sd18000;

  typedef enum logic [2:0] {
    REG_FRONT_X = 3'd0,
    REG_FRONT_Y = 3'd1,
    REG_LEFT_X  = 3'd2,
    REG_LEFT_Y  = 3'd3,
    REG_RIGHT_X = 3'd4,
    REG_RIGHT_Y = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } anchors_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DET_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               solved;
  } fix_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        range_mm;
    logic signed [15:0] bearing;
    logic               solved;
  } res_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      0:  a = 26'sd1152000;
      1:  a = 26'sd680065;
      2:  a = 26'sd359328;
      3:  a = 26'sd182400;
      4:  a = 26'sd91554;
      5:  a = 26'sd45822;
      6:  a = 26'sd22916;
      7:  a = 26'sd11459;
      8:  a = 26'sd5730;
      9:  a = 26'sd2865;
      10: a = 26'sd1432;
      11: a = 26'sd716;
      12: a = 26'sd358;
      13: a = 26'sd179;
      14: a = 26'sd90;
      15: a = 26'sd45;
      16: a = 26'sd22;
      17: a = 26'sd11;
      18: a = 26'sd6;
      19: a = 26'sd3;
      20: a = 26'sd1;
      21: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/tat_coef.sv]
// ----------------------------------------------------------------------------
// tat_coef
// Four-stage build of the linear system: squares, C and F, products, numerators.
// ----------------------------------------------------------------------------
module tat_coef (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  tat_pkg::anchors_t  anchors,
  input  logic [15:0]        dist_front,
  input  logic [15:0]        dist_left,
  input  logic [15:0]        dist_right,
  output logic               dn_valid,
  input  logic               dn_stall,
  output tat_pkg::div_in_t   dn_data
);

  localparam int NST = 4;

  logic [NST-1:0] v;
  logic [NST:0]   en;
  logic [NST-1:0] vin;

  assign en[NST] = !dn_stall;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin      = {v[NST-2:0], up_valid};
  assign up_stall = !en[0];
  assign dn_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  // stage 1
  logic signed [16:0] da, db, dd, de;
  logic signed [31:0] p_fx, p_fy, p_lx, p_ly, p_rx, p_ry;
  logic [31:0] p_df, p_dl, p_dr;

  assign da = 17'(anchors.left_x) - 17'(anchors.front_x);
  assign db = 17'(anchors.left_y) - 17'(anchors.front_y);
  assign dd = 17'(anchors.right_x) - 17'(anchors.left_x);
  assign de = 17'(anchors.right_y) - 17'(anchors.left_y);
  assign p_fx = anchors.front_x * anchors.front_x;
  assign p_fy = anchors.front_y * anchors.front_y;
  assign p_lx = anchors.left_x * anchors.left_x;
  assign p_ly = anchors.left_y * anchors.left_y;
  assign p_rx = anchors.right_x * anchors.right_x;
  assign p_ry = anchors.right_y * anchors.right_y;
  assign p_df = dist_front * dist_front;
  assign p_dl = dist_left * dist_left;
  assign p_dr = dist_right * dist_right;

  logic signed [tat_pkg::COEF_W-1:0] a1, b1, d1, e1;
  logic [30:0] sfx, sfy, slx, sly, srx, sry;
  logic [31:0] sdf, sdl, sdr;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1  <= $signed({da, 1'b0});
      b1  <= $signed({db, 1'b0});
      d1  <= $signed({dd, 1'b0});
      e1  <= $signed({de, 1'b0});
      sfx <= p_fx[30:0];
      sfy <= p_fy[30:0];
      slx <= p_lx[30:0];
      sly <= p_ly[30:0];
      srx <= p_rx[30:0];
      sry <= p_ry[30:0];
      sdf <= p_df;
      sdl <= p_dl;
      sdr <= p_dr;
    end
  end

  // stage 2
  logic signed [tat_pkg::CF_W-1:0] tdf, tdl, tdr, tfx, tfy, tlx, tly, trx, try_;
  logic signed [tat_pkg::DET_W-1:0] p_ae, p_bd;

  assign tdf  = $signed({3'b000, sdf});
  assign tdl  = $signed({3'b000, sdl});
  assign tdr  = $signed({3'b000, sdr});
  assign tfx  = $signed({4'b0000, sfx});
  assign tfy  = $signed({4'b0000, sfy});
  assign tlx  = $signed({4'b0000, slx});
  assign tly  = $signed({4'b0000, sly});
  assign trx  = $signed({4'b0000, srx});
  assign try_ = $signed({4'b0000, sry});
  assign p_ae = a1 * e1;
  assign p_bd = b1 * d1;

  logic signed [tat_pkg::CF_W-1:0]   c2, f2;
  logic signed [tat_pkg::COEF_W-1:0] a2, b2, d2, e2;
  logic signed [tat_pkg::DET_W-1:0]  ae2, bd2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2  <= tdf - tdl - tfx + tlx - tfy + tly;
      f2  <= tdl - tdr - tlx + trx - tly + try_;
      a2  <= a1;
      b2  <= b1;
      d2  <= d1;
      e2  <= e1;
      ae2 <= p_ae;
      bd2 <= p_bd;
    end
  end

  // stage 3
  logic signed [tat_pkg::NUM_W-1:0] p_ce, p_fb, p_af, p_cd;

  assign p_ce = c2 * e2;
  assign p_fb = f2 * b2;
  assign p_af = a2 * f2;
  assign p_cd = c2 * d2;

  logic signed [tat_pkg::NUM_W-1:0] ce3, fb3, af3, cd3;
  logic signed [tat_pkg::DET_W-1:0] det3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ce3  <= p_ce;
      fb3  <= p_fb;
      af3  <= p_af;
      cd3  <= p_cd;
      det3 <= ae2 - bd2;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en[3]) begin
      dn_data.num_x <= ce3 - fb3;
      dn_data.num_y <= af3 - cd3;
      dn_data.den   <= det3;
    end
  end

endmodule

[rtl/tat_div.sv]
// ----------------------------------------------------------------------------
// tat_div
// Pipelined restoring divider for x and y, rounded half away, saturated.
// ----------------------------------------------------------------------------
module tat_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  tat_pkg::div_in_t  up_data,
  output logic              dn_valid,
  input  logic              dn_stall,
  output tat_pkg::fix_t     dn_data
);

  localparam int NQ  = tat_pkg::QUO_W;
  localparam int NST = NQ + 3;
  localparam int MW  = tat_pkg::MAG_W;

  logic [NST-1:0] v;
  logic [NST:0]   en;
  logic [NST-1:0] vin;

  assign en[NST] = !dn_stall;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin      = {v[NST-2:0], up_valid};
  assign up_stall = !en[0];
  assign dn_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  // magnitudes and signs
  logic signed [tat_pkg::NUM_W-1:0] neg_nx, neg_ny;
  logic signed [tat_pkg::DET_W-1:0] neg_den;

  assign neg_nx  = -up_data.num_x;
  assign neg_ny  = -up_data.num_y;
  assign neg_den = -up_data.den;

  logic [MW-1:0]              un0 [2];
  logic [tat_pkg::DEN_W-1:0]  ud0;
  logic [1:0]                 neg0;
  logic                       zero0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      un0[0] <= up_data.num_x[tat_pkg::NUM_W-1] ? MW'(neg_nx) : MW'(up_data.num_x);
      un0[1] <= up_data.num_y[tat_pkg::NUM_W-1] ? MW'(neg_ny) : MW'(up_data.num_y);
      ud0    <= up_data.den[tat_pkg::DET_W-1] ? neg_den[tat_pkg::DEN_W-1:0]
                                              : up_data.den[tat_pkg::DEN_W-1:0];
      neg0[0] <= up_data.num_x[tat_pkg::NUM_W-1] ^ up_data.den[tat_pkg::DET_W-1];
      neg0[1] <= up_data.num_y[tat_pkg::NUM_W-1] ^ up_data.den[tat_pkg::DET_W-1];
      zero0   <= (up_data.den == '0);
    end
  end

  // rounding bias and step pipeline
  logic [MW-1:0]             rem  [NQ+1][2];
  logic [NQ-1:0]             quo  [NQ+1][2];
  logic [tat_pkg::DEN_W-1:0] ud_s [NQ+1];
  logic [1:0]                neg_s[NQ+1];
  logic                      zero_s[NQ+1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0][0] <= un0[0] + MW'(ud0 >> 1);
      rem[0][1] <= un0[1] + MW'(ud0 >> 1);
      quo[0][0] <= '0;
      quo[0][1] <= '0;
      ud_s[0]   <= ud0;
      neg_s[0]  <= neg0;
      zero_s[0] <= zero0;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_step
    localparam int K = NQ - 1 - j;
    logic [MW-1:0] trial;
    assign trial = MW'(ud_s[j]) << K;
    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        for (int l = 0; l < 2; l++) begin
          if (rem[j][l] >= trial) begin
            rem[j+1][l] <= rem[j][l] - trial;
            quo[j+1][l] <= quo[j][l] | (NQ'(1) << K);
          end else begin
            rem[j+1][l] <= rem[j][l];
            quo[j+1][l] <= quo[j][l];
          end
        end
        ud_s[j+1]   <= ud_s[j];
        neg_s[j+1]  <= neg_s[j];
        zero_s[j+1] <= zero_s[j];
      end
    end
  end

  // saturate
  logic signed [15:0] sat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_s[NQ][l]) begin
        sat[l] = (quo[NQ][l] > NQ'(32768)) ? -16'sd32768 : -$signed(quo[NQ][l][15:0]);
      end else begin
        sat[l] = (quo[NQ][l] > NQ'(32767)) ? 16'sd32767 : $signed(quo[NQ][l][15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      dn_data.px     <= zero_s[NQ] ? 16'sd0 : sat[0];
      dn_data.py     <= zero_s[NQ] ? 16'sd0 : sat[1];
      dn_data.solved <= !zero_s[NQ];
    end
  end

endmodule

[rtl/tat_polar.sv]
// ----------------------------------------------------------------------------
// tat_polar
// Range by digit-serial square root and bearing by CORDIC, one step a stage.
// ----------------------------------------------------------------------------
module tat_polar (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  tat_pkg::fix_t  up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output tat_pkg::res_t  dn_data
);

  localparam int N   = tat_pkg::POLAR_STEPS;
  localparam int NST = N + 2;
  localparam int CW  = tat_pkg::CRD_W;
  localparam int AW  = tat_pkg::ANG_W;
  localparam int RW  = tat_pkg::SQ_REM_W;
  localparam int SW  = tat_pkg::SQ_W;

  logic [NST-1:0] v;
  logic [NST:0]   en;
  logic [NST-1:0] vin;

  assign en[NST] = !dn_stall;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin      = {v[NST-2:0], up_valid};
  assign up_stall = !en[0];
  assign dn_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  logic [RW-1:0]          rem_s [N+1];
  logic [SW-1:0]          root_s[N+1];
  logic signed [CW-1:0]   cx    [N+1];
  logic signed [CW-1:0]   cy    [N+1];
  logic signed [AW-1:0]   cz    [N+1];
  logic signed [15:0]     px_s  [N+1];
  logic signed [15:0]     py_s  [N+1];
  logic                   org_s [N+1];
  logic                   ok_s  [N+1];

  // init
  logic signed [31:0]   sq_x, sq_y;
  logic signed [CW-1:0] x0, y0;

  assign sq_x = up_data.px * up_data.px;
  assign sq_y = up_data.py * up_data.py;
  assign x0   = CW'($signed({up_data.py, 16'd0}));
  assign y0   = CW'($signed({up_data.px, 16'd0}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_s[0]  <= RW'(sq_x) + RW'(sq_y);
      root_s[0] <= '0;
      if (up_data.py[15]) begin
        cx[0] <= -x0;
        cy[0] <= -y0;
        cz[0] <= up_data.px[15] ? -tat_pkg::HALF_TURN : tat_pkg::HALF_TURN;
      end else begin
        cx[0] <= x0;
        cy[0] <= y0;
        cz[0] <= '0;
      end
      px_s[0]  <= up_data.px;
      py_s[0]  <= up_data.py;
      org_s[0] <= (up_data.px == 16'sd0) && (up_data.py == 16'sd0);
      ok_s[0]  <= up_data.solved;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    if (j < tat_pkg::SQRT_STEPS) begin : g_sq
      localparam int K = tat_pkg::SQRT_STEPS - 1 - j;
      logic [RW-1:0] trial;
      assign trial = (RW'(root_s[j]) << (K + 1)) | (RW'(1) << (2 * K));
      always_ff @(posedge clk) begin
        if (en[j+1]) begin
          if (rem_s[j] >= trial) begin
            rem_s[j+1]  <= rem_s[j] - trial;
            root_s[j+1] <= root_s[j] | (SW'(1) << K);
          end else begin
            rem_s[j+1]  <= rem_s[j];
            root_s[j+1] <= root_s[j];
          end
        end
      end
    end else begin : g_sq_hold
      always_ff @(posedge clk) begin
        if (en[j+1]) begin
          rem_s[j+1]  <= rem_s[j];
          root_s[j+1] <= root_s[j];
        end
      end
    end

    if (j < tat_pkg::CORDIC_STEPS) begin : g_rot
      logic signed [CW-1:0] dx, dy;
      assign dx = cy[j] >>> j;
      assign dy = cx[j] >>> j;
      always_ff @(posedge clk) begin
        if (en[j+1]) begin
          if (!cy[j][CW-1]) begin
            cx[j+1] <= cx[j] + dx;
            cy[j+1] <= cy[j] - dy;
            cz[j+1] <= cz[j] + tat_pkg::atan_entry(j);
          end else begin
            cx[j+1] <= cx[j] - dx;
            cy[j+1] <= cy[j] + dy;
            cz[j+1] <= cz[j] - tat_pkg::atan_entry(j);
          end
        end
      end
    end else begin : g_rot_hold
      always_ff @(posedge clk) begin
        if (en[j+1]) begin
          cx[j+1] <= cx[j];
          cy[j+1] <= cy[j];
          cz[j+1] <= cz[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        px_s[j+1]  <= px_s[j];
        py_s[j+1]  <= py_s[j];
        org_s[j+1] <= org_s[j];
        ok_s[j+1]  <= ok_s[j];
      end
    end
  end

  // round and clamp
  logic signed [AW-1:0] zn, zr, cd;
  logic [SW-1:0]        rng;

  assign zn  = -cz[N];
  assign zr  = cz[N][AW-1] ? -((zn + tat_pkg::ANG_HALF) >>> tat_pkg::ANG_SHIFT)
                           : ((cz[N] + tat_pkg::ANG_HALF) >>> tat_pkg::ANG_SHIFT);
  assign cd  = (zr > tat_pkg::CD_MAX) ? tat_pkg::CD_MAX
             : (zr < -tat_pkg::CD_MAX) ? -tat_pkg::CD_MAX : zr;
  assign rng = root_s[N] + SW'(rem_s[N] > RW'(root_s[N]));

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      dn_data.pos_x    <= px_s[N];
      dn_data.pos_y    <= py_s[N];
      dn_data.range_mm <= rng;
      dn_data.bearing  <= org_s[N] ? 16'sd0 : cd[15:0];
      dn_data.solved   <= ok_s[N];
    end
  end

endmodule

[rtl/three_anchor_trilateration_polar_top.sv]
// ----------------------------------------------------------------------------
// three_anchor_trilateration_polar_top
// Throughput one item per cycle while fix_stall is low; the one-step-per-stage divider and CORDIC set it.
// Reset clears the pipeline and loads the default anchor positions.
// ----------------------------------------------------------------------------
`include "three_anchor_trilateration_polar_top_macros.svh"

module three_anchor_trilateration_polar_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               meas_valid,
  output logic               meas_stall,
  input  logic [15:0]        dist_front,
  input  logic [15:0]        dist_left,
  input  logic [15:0]        dist_right,
  output logic               fix_valid,
  input  logic               fix_stall,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic [15:0]        range_mm,
  output logic signed [15:0] bearing_centideg,
  output logic               solved
);

  tat_pkg::anchors_t anchors;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchors.front_x <= 16'sd0;
      anchors.front_y <= 16'sd400;
      anchors.left_x  <= -16'sd400;
      anchors.left_y  <= -16'sd400;
      anchors.right_x <= 16'sd400;
      anchors.right_y <= -16'sd400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tat_pkg::REG_FRONT_X: anchors.front_x <= cfg_data;
        tat_pkg::REG_FRONT_Y: anchors.front_y <= cfg_data;
        tat_pkg::REG_LEFT_X:  anchors.left_x  <= cfg_data;
        tat_pkg::REG_LEFT_Y:  anchors.left_y  <= cfg_data;
        tat_pkg::REG_RIGHT_X: anchors.right_x <= cfg_data;
        tat_pkg::REG_RIGHT_Y: anchors.right_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             coef_valid, coef_stall;
  tat_pkg::div_in_t coef_data;
  logic             div_valid, div_stall;
  tat_pkg::fix_t    div_data;
  tat_pkg::res_t    res;

  tat_coef u_coef (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (meas_valid),
    .up_stall   (meas_stall),
    .anchors    (anchors),
    .dist_front (dist_front),
    .dist_left  (dist_left),
    .dist_right (dist_right),
    .dn_valid   (coef_valid),
    .dn_stall   (coef_stall),
    .dn_data    (coef_data)
  );

  tat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (coef_valid),
    .up_stall (coef_stall),
    .up_data  (coef_data),
    .dn_valid (div_valid),
    .dn_stall (div_stall),
    .dn_data  (div_data)
  );

  tat_polar u_polar (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_valid),
    .up_stall (div_stall),
    .up_data  (div_data),
    .dn_valid (fix_valid),
    .dn_stall (fix_stall),
    .dn_data  (res)
  );

  assign pos_x            = res.pos_x;
  assign pos_y            = res.pos_y;
  assign range_mm         = res.range_mm;
  assign bearing_centideg = res.bearing;
  assign solved           = res.solved;

  `TAT_ASSERT(a_unsolved_zero, (fix_valid && !solved) |-> (pos_x == 16'sd0 && pos_y == 16'sd0 && range_mm == 16'd0 && bearing_centideg == 16'sd0))
  `TAT_ASSERT(a_bearing_bound, fix_valid |-> (bearing_centideg <= 16'sd18000 && bearing_centideg >= -16'sd18000))
  `TAT_ASSERT(a_range_bound, fix_valid |-> (range_mm <= 16'd46341))
  `TAT_ASSERT(a_free_flow, !fix_stall |-> !meas_stall)
  `TAT_ASSERT_NEXT(a_cfg_front_x, (cfg_valid && cfg_ready && cfg_index == tat_pkg::REG_FRONT_X), (anchors.front_x == $past(cfg_data)))

endmodule
